// ----- design/dtid_pkg.sv -----
// Package for the detection table: widths, opcodes, status codes and shared types.
// No dependencies.
package dtid_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int COORD_BITS  = 16;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = IDX_BITS + 1;
    localparam int AREA_BITS   = 2 * COORD_BITS;
    localparam int PROD_BITS   = AREA_BITS + 12;
    localparam int BOX_BITS    = 4 * COORD_BITS;
    localparam int ENTRY_BITS  = 8 + BOX_BITS + 16;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [2:0] ST_NEW       = 3'd0;
    localparam logic [2:0] ST_REPLACED  = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_OK        = 3'd4;

    localparam logic [10:0] IOU_RESET = 11'd768;
    localparam logic [11:0] AGE_RESET = 12'd5;

    localparam logic [0:0] CFG_IOU = 1'd0;
    localparam logic [0:0] CFG_AGE = 1'd1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  class_id;
        logic [15:0] box_left;
        logic [15:0] box_top;
        logic [15:0] box_right;
        logic [15:0] box_bottom;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_class;
        logic [15:0] out_left;
        logic [15:0] out_top;
        logic [15:0] out_right;
        logic [15:0] out_bottom;
        logic [6:0]  removed_count;
        logic        last;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic                load_req;
        logic                rd_en;
        logic [IDX_BITS-1:0] rd_addr;
        logic                cmp_en;
        logic                wr_en;
        logic [IDX_BITS-1:0] wr_addr;
        logic                set_valid;
        logic                clr_valid;
        logic                tick_now;
        logic                clr_count;
        logic                inc_count;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic          slot_valid;
        logic          class_hit;
        logic          iou_hit;
        logic          expired;
        logic          has_free;
        logic [IDX_BITS-1:0] free_slot;
        logic [1:0]    opcode;
    } dp_stat_t;

endpackage

// ----- design/dtid_if.sv -----
// Valid/ready channel interface carrying one payload beat.
// Depends on dtid_pkg for payload types.
interface dtid_req_if;
    logic               valid;
    logic               ready;
    dtid_pkg::req_t     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dtid_rsp_if;
    logic               valid;
    logic               ready;
    dtid_pkg::rsp_t     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/detection_table_iou_dedup.sv -----
// Top level of the detection table with IoU duplicate suppression.
// Depends on dtid_pkg, dtid_if, dtid_ram, dtid_datapath and dtid_ctrl.
//
//  channel | dir | handshake     | beat
//  --------+-----+---------------+-------------------------------------
//  req     | in  | valid/ready   | opcode, class_id, box bounds
//  rsp     | out | valid/ready   | status, class, box, removed_count, last
//  cfg     | in  | write enable  | index, 12-bit data
//
// Insert: up to 64 slots scanned one at a time through the IoU pipeline.
// Tick: one slot per cycle through the entry memory read port.
// Query: each slot is read, then decided before the next read.
// rst_n clears valid bits, seconds counter and control at once; no clearing pass.
// A stalled result holds the scan; input is taken only when the block is idle.
module detection_table_iou_dedup (
    input  logic              clk,
    input  logic              rst_n,
    dtid_req_if.sink          req,
    dtid_rsp_if.source        rsp,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [11:0]       cfg_data
);
    logic [10:0] match_thr_reg;
    logic [11:0] max_age_reg;
    dtid_pkg::dp_cmd_t  cmd;
    dtid_pkg::dp_stat_t stat;
    logic [7:0]  req_class;
    logic [dtid_pkg::BOX_BITS-1:0] ent_box;
    logic [6:0]  count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_thr_reg <= dtid_pkg::IOU_RESET;
            max_age_reg   <= dtid_pkg::AGE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dtid_pkg::CFG_IOU: match_thr_reg <= cfg_data[10:0];
                dtid_pkg::CFG_AGE: max_age_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    dtid_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req.data),
        .match_thr       (match_thr_reg),
        .max_age_seconds (max_age_reg),
        .cmd             (cmd),
        .stat            (stat),
        .ent_box         (ent_box),
        .req_class       (req_class),
        .count           (count)
    );

    dtid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (rsp.data),
        .cmd       (cmd),
        .stat      (stat),
        .ent_box   (ent_box),
        .req_class (req_class),
        .count     (count)
    );

    // no new item while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n) rsp.valid |-> !req.ready)
        else $error("input taken while result pending");
    // each tick result carries at most the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.status == dtid_pkg::ST_OK && rsp.data.out_class == 8'd0
        |-> rsp.data.removed_count <= 7'(dtid_pkg::TABLE_DEPTH))
        else $error("removed count beyond table size");
    // an accepted item starts the controller
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("ready stayed high after accept");
endmodule

// ----- design/dtid_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module dtid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ----- design/dtid_datapath.sv -----
// Datapath: entry memory, valid bits, seconds counter, IoU and age compare, result fields.
// Depends on dtid_pkg and dtid_ram.
module dtid_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  dtid_pkg::req_t     req,
    input  logic [10:0]        match_thr,
    input  logic [11:0]        max_age_seconds,
    input  dtid_pkg::dp_cmd_t  cmd,
    output dtid_pkg::dp_stat_t stat,
    output logic [dtid_pkg::BOX_BITS-1:0] ent_box,
    output logic [7:0]         req_class,
    output logic [6:0]         count
);
    localparam int CB = dtid_pkg::COORD_BITS;
    localparam int AB = dtid_pkg::AREA_BITS;
    localparam int PB = dtid_pkg::PROD_BITS;

    dtid_pkg::req_t req_reg;
    logic [dtid_pkg::TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [15:0] seconds_reg;
    logic [6:0]  count_reg;
    logic [dtid_pkg::ENTRY_BITS-1:0] rd_data, wr_data;
    logic [7:0]  ent_class;
    logic [15:0] ent_stamp;
    logic [dtid_pkg::IDX_BITS-1:0] rd_addr_q;
    logic                          has_free;
    logic [dtid_pkg::IDX_BITS-1:0] free_slot;

    // stage registers of the IoU compare
    logic [AB-1:0]  inter_reg, area_a_reg, area_b_reg;
    logic [AB:0]    union_reg;
    logic [PB-1:0]  lhs_reg, rhs_reg;
    logic           hit_reg;

    logic [CB-1:0] al, at, ar, ab, bl, bt, br, bb;
    logic [CB-1:0] iw, ih, wa, ha, wb, hb;
    logic [CB-1:0] mx_l, mn_r, mx_t, mn_b;
    logic [15:0]   age;

    dtid_ram #(.WIDTH(dtid_pkg::ENTRY_BITS), .DEPTH(dtid_pkg::TABLE_DEPTH)) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (cmd.wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_data)
    );

    assign ent_class = rd_data[dtid_pkg::ENTRY_BITS-1 -: 8];
    assign ent_box   = rd_data[16 +: dtid_pkg::BOX_BITS];
    assign ent_stamp = rd_data[15:0];

    // new slot and in-place replace both store the request box with the current second
    assign wr_data = {req_reg.class_id,
                      req_reg.box_bottom[CB-1:0], req_reg.box_right[CB-1:0],
                      req_reg.box_top[CB-1:0], req_reg.box_left[CB-1:0], seconds_reg};

    assign al = ent_box[0*CB +: CB];
    assign at = ent_box[1*CB +: CB];
    assign ar = ent_box[2*CB +: CB];
    assign ab = ent_box[3*CB +: CB];
    assign bl = req_reg.box_left[CB-1:0];
    assign bt = req_reg.box_top[CB-1:0];
    assign br = req_reg.box_right[CB-1:0];
    assign bb = req_reg.box_bottom[CB-1:0];

    always_comb
    begin
        mx_l = (al > bl) ? al : bl;
        mn_r = (ar < br) ? ar : br;
        mx_t = (at > bt) ? at : bt;
        mn_b = (ab < bb) ? ab : bb;
        iw = (mn_r > mx_l) ? mn_r - mx_l : '0;
        ih = (mn_b > mx_t) ? mn_b - mx_t : '0;
        wa = (ar > al) ? ar - al : '0;
        ha = (ab > at) ? ab - at : '0;
        wb = (br > bl) ? br - bl : '0;
        hb = (bb > bt) ? bb - bt : '0;
    end

    assign age = seconds_reg - ent_stamp;

    always_ff @(posedge clk)
    begin
        // stage 1: products
        inter_reg  <= iw * ih;
        area_a_reg <= wa * ha;
        area_b_reg <= wb * hb;
        // stage 2: union
        union_reg  <= {1'b0, area_a_reg} + {1'b0, area_b_reg} - {1'b0, inter_reg};
        // stage 3: scaled products
        lhs_reg    <= {inter_reg, 10'd0};
        rhs_reg    <= PB'(match_thr) * PB'(union_reg);
        // stage 4: compare
        hit_reg    <= lhs_reg > rhs_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
        // hold the address of the slot whose data sits on the read port
        if (cmd.rd_en)
        begin
            rd_addr_q <= cmd.rd_addr;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.set_valid)
        begin
            valid_next[cmd.wr_addr] = 1'b1;
        end
        if (cmd.clr_valid)
        begin
            valid_next[cmd.wr_addr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            seconds_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmd.tick_now)
            begin
                seconds_reg <= seconds_reg + 16'd1;
            end
            if (cmd.clr_count)
            begin
                count_reg <= '0;
            end
            else if (cmd.inc_count)
            begin
                count_reg <= count_reg + 7'd1;
            end
        end
    end

    // lowest free slot, priority search
    always_comb
    begin
        has_free  = 1'b0;
        free_slot = '0;
        for (int i = dtid_pkg::TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                has_free  = 1'b1;
                free_slot = dtid_pkg::IDX_BITS'(i);
            end
        end
    end

    assign stat.has_free   = has_free;
    assign stat.free_slot  = free_slot;
    assign stat.slot_valid = valid_reg[rd_addr_q];
    assign stat.class_hit  = ent_class == req_reg.class_id;
    assign stat.iou_hit    = hit_reg;
    assign stat.expired    = age > {4'd0, max_age_seconds};
    assign stat.opcode     = req_reg.opcode;
    assign req_class       = req_reg.class_id;
    assign count           = count_reg;
endmodule

// ----- design/dtid_ctrl.sv -----
// Controller: sequences the slot scan for insert, tick and query and drives the result.
// Depends on dtid_pkg.
module dtid_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output dtid_pkg::rsp_t     out_data,
    output dtid_pkg::dp_cmd_t  cmd,
    input  dtid_pkg::dp_stat_t stat,
    input  logic [dtid_pkg::BOX_BITS-1:0] ent_box,
    input  logic [7:0]         req_class,
    input  logic [6:0]         count
);
    localparam int IB = dtid_pkg::IDX_BITS;
    localparam int CB = dtid_pkg::COORD_BITS;
    localparam int PIPE = 5;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_INS   = 3'd2;
    localparam logic [2:0] S_TICK  = 3'd3;
    localparam logic [2:0] S_QRY   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;
    localparam logic [2:0] S_WAIT  = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [IB:0]   idx_reg, idx_next;   // slot being read
    logic [IB:0]   chk_reg, chk_next;   // slot being decided
    logic [2:0]    wait_reg, wait_next;
    logic          out_valid_reg, out_valid_next;
    dtid_pkg::rsp_t out_reg, out_next;
    logic          pend_reg, pend_next; // a query hit waits to go out
    dtid_pkg::rsp_t pend_data_reg, pend_data_next;

    assign in_ready  = state_reg == S_IDLE && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        chk_next       = chk_reg;
        wait_next      = wait_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        pend_next      = pend_reg;
        pend_data_next = pend_data_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load_req  = 1'b1;
                    cmd.clr_count = 1'b1;
                    idx_next      = '0;
                    state_next    = S_DISP;
                end
            end
            S_DISP:
            begin
                idx_next  = '0;
                chk_next  = '0;
                wait_next = '0;
                pend_next = 1'b0;
                priority case (stat.opcode)
                    dtid_pkg::OP_INSERT: state_next = S_INS;
                    dtid_pkg::OP_TICK:
                    begin
                        cmd.tick_now = 1'b1;
                        state_next   = S_TICK;
                    end
                    dtid_pkg::OP_QUERY: state_next = S_QRY;
                    default:            state_next = S_IDLE;
                endcase
            end
            S_INS:
            begin
                // one slot in flight at a time through the IoU stages
                if (wait_reg == 3'd0)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = chk_reg[IB-1:0];
                    wait_next   = 3'd1;
                end
                else if (wait_reg != 3'(PIPE))
                begin
                    wait_next = wait_reg + 3'd1;
                end
                else
                begin
                    wait_next = '0;
                    if (stat.slot_valid && stat.class_hit && stat.iou_hit)
                    begin
                        cmd.wr_en        = 1'b1;
                        cmd.wr_addr      = chk_reg[IB-1:0];
                        out_next         = '0;
                        out_next.status  = dtid_pkg::ST_REPLACED;
                        out_next.last    = 1'b1;
                        state_next       = S_OUT;
                    end
                    else if (chk_reg == (IB+1)'(dtid_pkg::TABLE_DEPTH - 1))
                    begin
                        out_next      = '0;
                        out_next.last = 1'b1;
                        if (stat.has_free)
                        begin
                            cmd.wr_en       = 1'b1;
                            cmd.wr_addr     = stat.free_slot;
                            cmd.set_valid   = 1'b1;
                            out_next.status = dtid_pkg::ST_NEW;
                        end
                        else
                        begin
                            out_next.status = dtid_pkg::ST_FULL;
                        end
                        state_next = S_OUT;
                    end
                    else
                    begin
                        chk_next = chk_reg + 1'b1;
                    end
                end
            end
            S_TICK:
            begin
                // read slot idx, decide slot chk in the following cycle
                if (idx_reg != (IB+1)'(dtid_pkg::TABLE_DEPTH))
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = idx_reg[IB-1:0];
                    idx_next    = idx_reg + 1'b1;
                end
                if (idx_reg != '0)
                begin
                    if (stat.slot_valid && stat.expired)
                    begin
                        cmd.clr_valid = 1'b1;
                        cmd.wr_addr   = chk_reg[IB-1:0];
                        cmd.inc_count = 1'b1;
                    end
                    chk_next = chk_reg + 1'b1;
                    if (chk_reg == (IB+1)'(dtid_pkg::TABLE_DEPTH - 1))
                    begin
                        state_next = S_WAIT;
                    end
                end
            end
            S_WAIT:
            begin
                out_next               = '0;
                out_next.status        = dtid_pkg::ST_OK;
                out_next.removed_count = count;
                out_next.last          = 1'b1;
                state_next             = S_OUT;
            end
            S_QRY:
            begin
                // hold a found slot until the next one or the end decides last
                if (!out_valid_next)
                begin
                    if (wait_reg == 3'd0)
                    begin
                        if (chk_reg == (IB+1)'(dtid_pkg::TABLE_DEPTH))
                        begin
                            out_next = pend_reg ? pend_data_reg : '0;
                            if (!pend_reg)
                            begin
                                out_next.status = dtid_pkg::ST_NOT_FOUND;
                            end
                            out_next.last = 1'b1;
                            state_next    = S_OUT;
                        end
                        else
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_addr = chk_reg[IB-1:0];
                            wait_next   = 3'd1;
                        end
                    end
                    else
                    begin
                        wait_next = '0;
                        chk_next  = chk_reg + 1'b1;
                        if (stat.slot_valid && stat.class_hit)
                        begin
                            if (pend_reg)
                            begin
                                out_next       = pend_data_reg;
                                out_valid_next = 1'b1;
                            end
                            pend_next                 = 1'b1;
                            pend_data_next            = '0;
                            pend_data_next.status     = dtid_pkg::ST_OK;
                            pend_data_next.out_class  = req_class;
                            pend_data_next.out_left   = 16'(ent_box[0*CB +: CB]);
                            pend_data_next.out_top    = 16'(ent_box[1*CB +: CB]);
                            pend_data_next.out_right  = 16'(ent_box[2*CB +: CB]);
                            pend_data_next.out_bottom = 16'(ent_box[3*CB +: CB]);
                        end
                    end
                end
            end
            S_OUT:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            chk_reg       <= '0;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            chk_reg       <= chk_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg       <= out_next;
        pend_data_reg <= pend_data_next;
    end
endmodule

// ----- bench/dtid_tb_pkg.sv -----
`timescale 1ns / 1ps
// Testbench-side helpers for the detection table bench: the slot type and the IoU test.
// Depends on dtid_pkg for the request type.
package dtid_tb_pkg;
    import dtid_pkg::*;

    typedef struct {
        bit          valid;
        logic [7:0]  cls;
        logic [15:0] l, t, r, b;
        logic [15:0] stamp;
    } slot_t;

    function automatic longint unsigned extent(logic [15:0] lo, logic [15:0] hi);
        return (hi > lo) ? longint'(hi - lo) : 0;
    endfunction

    // IoU test by cross multiplication; true when the overlap beats the threshold
    function automatic bit boxes_overlap(slot_t a, req_t q, logic [10:0] thr);
        longint unsigned iw, ih, inter, ua, ub, un;
        iw = extent((a.l > q.box_left) ? a.l : q.box_left,
                    (a.r < q.box_right) ? a.r : q.box_right);
        ih = extent((a.t > q.box_top) ? a.t : q.box_top,
                    (a.b < q.box_bottom) ? a.b : q.box_bottom);
        inter = iw * ih;
        ua = extent(a.l, a.r) * extent(a.t, a.b);
        ub = extent(q.box_left, q.box_right) * extent(q.box_top, q.box_bottom);
        un = ua + ub - inter;
        return inter * 1024 > longint'(thr) * un;
    endfunction
endpackage

// ----- bench/detection_table_iou_dedup_tb.sv -----
`timescale 1ns / 1ps
// Bench for detection_table_iou_dedup: random and directed inserts, ticks and queries,
// checked beat by beat against a table model. Depends on dtid_pkg, dtid_if, dtid_tb_pkg.
module detection_table_iou_dedup_tb;
    import dtid_pkg::*;
    import dtid_tb_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [0:0]  cfg_index = '0;
    logic [11:0] cfg_data = '0;

    dtid_req_if req ();
    dtid_rsp_if rsp ();

    detection_table_iou_dedup u_dut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    slot_t       table_q [TABLE_DEPTH];
    logic [15:0] seconds_now;
    logic [10:0] iou_thr;
    logic [11:0] age_limit;

    req_t  pending_reqs [$];
    rsp_t  expected_rsps [$];
    int    errors = 0;
    int    beats_checked = 0;
    int    reqs_sent = 0;
    int    send_idle_pct = 25;
    int    recv_idle_pct = 25;
    int    recv_hold = 0;
    bit    send_pause = 0;
    bit    stim_done = 0;
    bit    in_taken = 0;

    initial forever #5 clk = ~clk;

    task automatic add_req(req_t q);
        pending_reqs = {pending_reqs, q};
    endtask

    task automatic add_rsp(rsp_t r);
        expected_rsps = {expected_rsps, r};
    endtask

    // Model one accepted request and queue the beats it causes.
    task automatic predict_table(req_t q);
        rsp_t rr;
        int   hits, freeslot, removed;
        rr = '0;
        rr.last = 1'b1;
        case (q.opcode)
            OP_INSERT: begin
                hits = 0;
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (hits == 0 && table_q[i].valid && table_q[i].cls == q.class_id
                        && boxes_overlap(table_q[i], q, iou_thr)) begin
                        table_q[i].l = q.box_left;  table_q[i].t = q.box_top;
                        table_q[i].r = q.box_right; table_q[i].b = q.box_bottom;
                        table_q[i].stamp = seconds_now;
                        hits = 1;
                    end
                if (hits) rr.status = ST_REPLACED;
                else begin
                    freeslot = -1;
                    for (int i = TABLE_DEPTH - 1; i >= 0; i--)
                        if (!table_q[i].valid) freeslot = i;
                    if (freeslot < 0) rr.status = ST_FULL;
                    else begin
                        table_q[freeslot] = '{1'b1, q.class_id, q.box_left, q.box_top,
                                              q.box_right, q.box_bottom, seconds_now};
                        rr.status = ST_NEW;
                    end
                end
                add_rsp(rr);
            end
            OP_TICK: begin
                removed = 0;
                seconds_now = seconds_now + 16'd1;
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (table_q[i].valid && 16'(seconds_now - table_q[i].stamp) > age_limit)
                    begin
                        table_q[i].valid = 0;
                        removed++;
                    end
                rr.status = ST_OK;
                rr.removed_count = 7'(removed);
                add_rsp(rr);
            end
            OP_QUERY: begin
                hits = 0;
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (table_q[i].valid && table_q[i].cls == q.class_id) begin
                        rr = '0;
                        rr.status = ST_OK;
                        rr.out_class = q.class_id;
                        rr.out_left = table_q[i].l;  rr.out_top = table_q[i].t;
                        rr.out_right = table_q[i].r; rr.out_bottom = table_q[i].b;
                        add_rsp(rr);
                        hits++;
                    end
                if (hits == 0) begin
                    rr = '0;
                    rr.status = ST_NOT_FOUND;
                    rr.last = 1'b1;
                    add_rsp(rr);
                end else
                    expected_rsps[$].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    // Input side: record the accepted beat at the edge that takes it.
    always @(posedge clk) begin
        in_taken = (rst_n && req.valid && req.ready);
        if (in_taken) begin
            predict_table(req.data);
            reqs_sent++;
        end
    end

    // Driver: hold the offered beat until taken, then present the next pending item.
    always @(negedge clk) begin
        if (rst_n) begin
            if (!req.valid || in_taken) begin
                if (pending_reqs.size() != 0 && !send_pause
                    && $urandom_range(99) >= send_idle_pct) begin
                    req.data <= pending_reqs.pop_front();
                    req.valid <= 1'b1;
                end else
                    req.valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, long hold when requested.
    always @(negedge clk) begin
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            rsp.ready <= 1'b0;
        end else
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: compare every accepted beat with the oldest expectation.
    always @(posedge clk) begin
        rsp_t got, want;
        if (rst_n && rsp.valid && rsp.ready) begin
            got = rsp.data;
            if (expected_rsps.size() == 0) begin
                $error("unexpected result beat %p", got);
                errors++;
            end else begin
                want = expected_rsps.pop_front();
                beats_checked++;
                if (got.status !== want.status) begin
                    $error("status: expected %0d got %0d", want.status, got.status); errors++;
                end
                if (got.out_class !== want.out_class) begin
                    $error("out_class: expected %0d got %0d", want.out_class, got.out_class);
                    errors++;
                end
                if (got.out_left !== want.out_left) begin
                    $error("out_left: expected %0d got %0d", want.out_left, got.out_left);
                    errors++;
                end
                if (got.out_top !== want.out_top) begin
                    $error("out_top: expected %0d got %0d", want.out_top, got.out_top);
                    errors++;
                end
                if (got.out_right !== want.out_right) begin
                    $error("out_right: expected %0d got %0d", want.out_right, got.out_right);
                    errors++;
                end
                if (got.out_bottom !== want.out_bottom) begin
                    $error("out_bottom: expected %0d got %0d", want.out_bottom, got.out_bottom);
                    errors++;
                end
                if (got.removed_count !== want.removed_count) begin
                    $error("removed_count: expected %0d got %0d",
                           want.removed_count, got.removed_count);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0d got %0d", want.last, got.last); errors++;
                end
            end
        end
    end

    function automatic req_t make_req(logic [1:0] op, logic [7:0] c, logic [15:0] l,
                                      logic [15:0] t, logic [15:0] r, logic [15:0] b);
        req_t q;
        q.opcode = op; q.class_id = c;
        q.box_left = l; q.box_top = t; q.box_right = r; q.box_bottom = b;
        return q;
    endfunction

    // Random item: mostly inserts around a few anchor boxes on few classes so that
    // matches, replacements and a full table all happen.
    function automatic req_t rand_req();
        req_t q;
        int   k, base, w;
        k = $urandom_range(99);
        q.class_id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
        if ($urandom_range(15) == 0) begin
            q.box_left = 16'($urandom); q.box_top = 16'($urandom);
            q.box_right = 16'($urandom); q.box_bottom = 16'($urandom);
        end else begin
            base = $urandom_range(7) * 8000;
            w = $urandom_range(4000, 100);
            q.box_left = 16'(base + $urandom_range(60));
            q.box_top = 16'(base + $urandom_range(60));
            q.box_right = 16'(base + w + $urandom_range(60));
            q.box_bottom = 16'(base + w + $urandom_range(60));
        end
        if (k < 62) q.opcode = OP_INSERT;
        else if (k < 80) q.opcode = OP_TICK;
        else if (k < 97) q.opcode = OP_QUERY;
        else q.opcode = 2'd3;
        return q;
    endfunction

    task automatic drain();
        wait (pending_reqs.size() == 0 && !req.valid && expected_rsps.size() == 0);
        repeat (450) @(posedge clk);
    endtask

    task automatic write_cfg(logic [0:0] idx, logic [11:0] val);
        @(negedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_IOU) iou_thr = val[10:0];
        else age_limit = val;
    endtask

    initial begin
        req.valid = 0; req.data = '0; rsp.ready = 0;
        seconds_now = 0; iou_thr = IOU_RESET; age_limit = AGE_RESET;
        foreach (table_q[i]) table_q[i].valid = 0;
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n = 1;

        // directed: extremes, every opcode, degenerate and empty boxes
        add_req(make_req(OP_QUERY, 8'd0, 0, 0, 0, 0));
        add_req(make_req(OP_INSERT, 8'd0, 0, 0, 0, 0));
        add_req(make_req(OP_INSERT, 8'd0, 0, 0, 0, 0));
        add_req(make_req(OP_INSERT, 8'd255, 0, 0, 16'hFFFF, 16'hFFFF));
        add_req(make_req(OP_INSERT, 8'd255, 1, 1, 16'hFFFF, 16'hFFFF));
        add_req(make_req(OP_INSERT, 8'd7, 100, 100, 50, 200));
        add_req(make_req(OP_INSERT, 8'd7, 100, 100, 50, 200));
        add_req(make_req(OP_INSERT, 8'd7, 10, 10, 110, 110));
        add_req(make_req(OP_INSERT, 8'd7, 12, 12, 110, 110));
        add_req(make_req(2'd3, 8'hAA, 16'hFFFF, 0, 16'hFFFF, 0));
        add_req(make_req(OP_QUERY, 8'd7, 0, 0, 0, 0));
        add_req(make_req(OP_QUERY, 8'd255, 16'hFFFF, 16'hFFFF, 0, 0));
        add_req(make_req(OP_TICK, 8'd0, 0, 0, 0, 0));
        drain();

        // threshold 0 and 1024+ extremes
        write_cfg(CFG_IOU, 12'd0);
        write_cfg(CFG_AGE, 12'd0);
        add_req(make_req(OP_INSERT, 8'd7, 10, 10, 11, 11));
        add_req(make_req(OP_INSERT, 8'd7, 109, 109, 110, 110));
        add_req(make_req(OP_INSERT, 8'd7, 1000, 1000, 1001, 1001));
        add_req(make_req(OP_TICK, 8'd0, 0, 0, 0, 0));
        add_req(make_req(OP_TICK, 8'd0, 0, 0, 0, 0));
        drain();
        write_cfg(CFG_IOU, 12'd2047);
        write_cfg(CFG_AGE, 12'd4095);
        add_req(make_req(OP_INSERT, 8'd1, 0, 0, 16'hFFFF, 16'hFFFF));
        add_req(make_req(OP_INSERT, 8'd1, 0, 0, 16'hFFFF, 16'hFFFF));
        add_req(make_req(OP_QUERY, 8'd1, 0, 0, 0, 0));
        drain();

        // long age: fill table past full with random boxes, receiver holds off
        write_cfg(CFG_IOU, 12'd1024);
        for (int i = 0; i < 70; i++) begin
            add_req(make_req(OP_INSERT, 8'd2, 16'(i * 900), 16'($urandom),
                             16'(i * 900 + 50), 16'($urandom)));
        end
        add_req(make_req(OP_QUERY, 8'd2, 0, 0, 0, 0));
        recv_hold = 400;
        drain();

        // random phases through several settings; sender pauses midway in each
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin write_cfg(CFG_IOU, 12'd768); write_cfg(CFG_AGE, 12'd5); end
                1: begin write_cfg(CFG_IOU, 12'd300); write_cfg(CFG_AGE, 12'd3600); end
                2: begin write_cfg(CFG_IOU, 12'd1);   write_cfg(CFG_AGE, 12'd2); end
                default: begin write_cfg(CFG_IOU, 12'($urandom_range(1024)));
                               write_cfg(CFG_AGE, 12'($urandom_range(12))); end
            endcase
            send_idle_pct = (ph == 1) ? 0 : 25;
            recv_idle_pct = (ph == 1) ? 0 : 25;
            for (int i = 0; i < 92; i++) add_req(rand_req());
            // hold the sender until everything in flight has landed
            wait (pending_reqs.size() <= 46);
            send_pause = 1;
            wait (expected_rsps.size() == 0);
            send_pause = 0;
            drain();
        end

        $display("covered %0d requests and %0d result beats over several thresholds and ages",
                 reqs_sent, beats_checked);
        if (errors == 0)
            $display("[detection_table_iou_dedup] OK");
        else
            $display("[detection_table_iou_dedup] ERROR");
        $finish;
    end

    initial begin
        #60ms;
        $display("[detection_table_iou_dedup] ERROR");
        $finish;
    end
endmodule
